FILE: hdl/cmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_pkg: shared codes and types for the extended CIGAR refiner
// Holds function codes, BAM op codes, fixed field widths and the result word.
// ----------------------------------------------------------------------------
package cmr_pkg;

	localparam int FUNC_W     = 3;
	localparam int OP_W       = 4;
	localparam int CIGAR_LEN_W = 28;
	localparam int EDIT_W     = 32;
	localparam int IN_BASE_W  = 8;
	localparam int IN_LEN_W   = 28;
	localparam int S_TDATA_W  = 104;
	localparam int M_TDATA_W  = 64;

	// Input function codes
	localparam logic [FUNC_W-1:0] FUNC_START  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALIGN  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_INS    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DEL    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd4;

	// BAM op codes
	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_INS  = 4'd1;
	localparam logic [OP_W-1:0] OP_DEL  = 4'd2;
	localparam logic [OP_W-1:0] OP_SOFT = 4'd4;
	localparam logic [OP_W-1:0] OP_EQ   = 4'd7;
	localparam logic [OP_W-1:0] OP_DIFF = 4'd8;

	typedef struct packed {
		logic                   valid;
		logic [OP_W-1:0]        op;
		logic [CIGAR_LEN_W-1:0] len;
	} cigar_word_t;

	localparam cigar_word_t EMPTY_WORD = '{valid: 1'b0, op: OP_NONE, len: '0};

endpackage

FILE: hdl/cmr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_step: one-item update of the run tracker
// Computes the next run state, the edit count and up to two CIGAR words.
// ----------------------------------------------------------------------------
module cmr_step #(
	parameter int LENGTH_BITS = 28,
	parameter int BASE_BITS   = 8
) (
	input  logic [cmr_pkg::FUNC_W-1:0] func,
	input  logic [BASE_BITS-1:0]       ref_base,
	input  logic [BASE_BITS-1:0]       query_base,
	input  logic [LENGTH_BITS-1:0]     op_length,
	input  logic [LENGTH_BITS-1:0]     query_length,
	input  logic [LENGTH_BITS-1:0]     query_end_pos,
	input  logic                       in_match,
	input  logic                       in_mismatch,
	input  logic [LENGTH_BITS-1:0]     match_len,
	input  logic [LENGTH_BITS-1:0]     mismatch_len,
	input  logic [cmr_pkg::EDIT_W-1:0] edit_count,
	output logic                       in_match_nx,
	output logic                       in_mismatch_nx,
	output logic [LENGTH_BITS-1:0]     match_len_nx,
	output logic [LENGTH_BITS-1:0]     mismatch_len_nx,
	output logic [cmr_pkg::EDIT_W-1:0] edit_count_nx,
	output cmr_pkg::cigar_word_t       word0,
	output cmr_pkg::cigar_word_t       word1,
	output logic                       two_words
);
	import cmr_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	function automatic cigar_word_t mk_word(input logic [OP_W-1:0] op,
		input logic [LENGTH_BITS-1:0] len);
		cigar_word_t w;
		w.valid = 1'b1;
		w.op    = op;
		w.len   = CIGAR_LEN_W'(len);
		return w;
	endfunction

	logic [EDIT_W:0]        edit_sum;
	logic [LENGTH_BITS-1:0] edit_add;
	logic [LENGTH_BITS:0]   qend_p1;
	logic [LENGTH_BITS-1:0] clip_len;
	cigar_word_t            run_word;
	cigar_word_t            slot_a;
	cigar_word_t            slot_b;

	// edits added by this item: one per mismatch, the length of an indel
	assign edit_add = (func == FUNC_ALIGN) ?
			((ref_base != query_base) ? LENGTH_BITS'(1) : '0) :
		(func == FUNC_INS || func == FUNC_DEL) ? op_length : '0;

	// saturating edit add: anything past the top pins at all ones
	assign edit_sum = {1'b0, edit_count} + (EDIT_W+1)'(edit_add);
	assign qend_p1  = {1'b0, query_end_pos} + (LENGTH_BITS+1)'(1);
	assign clip_len = query_length - query_end_pos - LENGTH_BITS'(1);

	always_comb begin
		if (in_match) begin
			run_word = mk_word(OP_EQ, match_len);
		end else if (in_mismatch) begin
			run_word = mk_word(OP_DIFF, mismatch_len);
		end else begin
			run_word = EMPTY_WORD;
		end
	end

	always_comb begin
		in_match_nx     = in_match;
		in_mismatch_nx  = in_mismatch;
		match_len_nx    = match_len;
		mismatch_len_nx = mismatch_len;
		edit_count_nx   = edit_count;
		slot_a          = EMPTY_WORD;
		slot_b          = EMPTY_WORD;
		unique case (func)
			FUNC_START: begin
				in_match_nx     = 1'b0;
				in_mismatch_nx  = 1'b0;
				match_len_nx    = '0;
				mismatch_len_nx = '0;
				edit_count_nx   = '0;
				if (op_length != '0) begin
					slot_b = mk_word(OP_SOFT, op_length);
				end
			end
			FUNC_ALIGN: begin
				edit_count_nx = edit_sum[EDIT_W] ? '1 : edit_sum[EDIT_W-1:0];
				if (ref_base != query_base) begin
					if (in_match) begin
						slot_a = mk_word(OP_EQ, match_len);
					end
					match_len_nx = '0;
					// split an overlong run: emit the full word, restart at one
					if (in_mismatch && mismatch_len == LEN_MAX) begin
						slot_a = mk_word(OP_DIFF, LEN_MAX);
						mismatch_len_nx = LENGTH_BITS'(1);
					end else begin
						mismatch_len_nx = mismatch_len + LENGTH_BITS'(1);
					end
					in_match_nx    = 1'b0;
					in_mismatch_nx = 1'b1;
				end else begin
					if (in_mismatch) begin
						slot_a = mk_word(OP_DIFF, mismatch_len);
					end
					mismatch_len_nx = '0;
					if (in_match && match_len == LEN_MAX) begin
						slot_a = mk_word(OP_EQ, LEN_MAX);
						match_len_nx = LENGTH_BITS'(1);
					end else begin
						match_len_nx = match_len + LENGTH_BITS'(1);
					end
					in_match_nx    = 1'b1;
					in_mismatch_nx = 1'b0;
				end
			end
			FUNC_INS, FUNC_DEL: begin
				edit_count_nx   = edit_sum[EDIT_W] ? '1 : edit_sum[EDIT_W-1:0];
				slot_a          = run_word;
				slot_b          = mk_word((func == FUNC_INS) ? OP_INS : OP_DEL, op_length);
				in_match_nx     = 1'b0;
				in_mismatch_nx  = 1'b0;
				match_len_nx    = '0;
				mismatch_len_nx = '0;
			end
			FUNC_FINISH: begin
				slot_a          = run_word;
				in_match_nx     = 1'b0;
				in_mismatch_nx  = 1'b0;
				match_len_nx    = '0;
				mismatch_len_nx = '0;
				if ({1'b0, query_length} > qend_p1) begin
					slot_b = mk_word(OP_SOFT, clip_len);
				end
			end
			default: begin
			end
		endcase
	end

	// compact the two slots so the first word is a real one whenever either slot holds one
	always_comb begin
		if (slot_a.valid) begin
			word0     = slot_a;
			word1     = slot_b;
			two_words = slot_b.valid;
		end else begin
			word0     = slot_b;
			word1     = EMPTY_WORD;
			two_words = 1'b0;
		end
	end

endmodule

FILE: hdl/cigar_match_mismatch_refiner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_match_mismatch_refiner: extended CIGAR writer with edit counter
// Turns start / aligned pair / indel / finish words into '=', 'X', I, D and
// S words and keeps a saturating count of mismatches plus indel bases.
// ----------------------------------------------------------------------------
// Path: each input word is taken into the input register and moves on into the
//   result register once the last result of the previous word has left.
// Throughput: one input word per cycle while each yields one result and
//   m_tready is high; a two-result word holds the result register for both.
// Reset: arst_n clears all valid flags and the run/edit state asynchronously.
// ----------------------------------------------------------------------------
module cigar_match_mismatch_refiner #(
	parameter int LENGTH_BITS = 28,
	parameter int BASE_BITS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] ref_base, [15:8] query_base, [43:16] op_length,
	// [71:44] query_length, [99:72] query_end_pos, [103:100] zero
	input  logic [cmr_pkg::S_TDATA_W-1:0] s_tdata,
	// [2:0] func
	input  logic [cmr_pkg::FUNC_W-1:0]    s_tuser,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] op_code, [31:4] cigar_length, [63:32] edit_total
	output logic [cmr_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] word_valid
	output logic                          m_tuser,
	// last result caused by the input word
	output logic                          m_tlast
);
	import cmr_pkg::*;

	// input register
	logic                     valid_s1;
	logic [FUNC_W-1:0]        func_s1;
	logic [BASE_BITS-1:0]     ref_base_s1;
	logic [BASE_BITS-1:0]     query_base_s1;
	logic [LENGTH_BITS-1:0]   op_length_s1;
	logic [LENGTH_BITS-1:0]   query_length_s1;
	logic [LENGTH_BITS-1:0]   query_end_pos_s1;

	// run tracker state
	logic                     in_match_q;
	logic                     in_mismatch_q;
	logic [LENGTH_BITS-1:0]   match_len_q;
	logic [LENGTH_BITS-1:0]   mismatch_len_q;
	logic [EDIT_W-1:0]        edit_count_q;

	logic                     in_match_nx;
	logic                     in_mismatch_nx;
	logic [LENGTH_BITS-1:0]   match_len_nx;
	logic [LENGTH_BITS-1:0]   mismatch_len_nx;
	logic [EDIT_W-1:0]        edit_count_nx;
	cigar_word_t              word0_nx;
	cigar_word_t              word1_nx;
	logic                     two_nx;

	// result register: up to two words per input, shown one after the other
	logic                     res_valid_q;
	logic                     res_two_q;
	logic                     res_sel_q;
	cigar_word_t              word0_q;
	cigar_word_t              word1_q;
	logic [EDIT_W-1:0]        res_edit_q;

	cigar_word_t              cur_word;
	logic                     out_fire;
	logic                     advance;

	assign m_tvalid = res_valid_q;
	assign m_tlast  = !res_two_q || res_sel_q;
	assign cur_word = res_sel_q ? word1_q : word0_q;
	assign m_tdata  = {res_edit_q, cur_word.len, cur_word.op};
	assign m_tuser  = cur_word.valid;
	assign out_fire = m_tvalid && m_tready;

	// move the held word into the result register when it is empty or its last result leaves
	assign advance  = valid_s1 && (!res_valid_q || (out_fire && m_tlast));
	assign s_tready = !valid_s1 || advance;

	cmr_step #(
		.LENGTH_BITS(LENGTH_BITS),
		.BASE_BITS  (BASE_BITS)
	) u_step (
		.func           (func_s1),
		.ref_base       (ref_base_s1),
		.query_base     (query_base_s1),
		.op_length      (op_length_s1),
		.query_length   (query_length_s1),
		.query_end_pos  (query_end_pos_s1),
		.in_match       (in_match_q),
		.in_mismatch    (in_mismatch_q),
		.match_len      (match_len_q),
		.mismatch_len   (mismatch_len_q),
		.edit_count     (edit_count_q),
		.in_match_nx    (in_match_nx),
		.in_mismatch_nx (in_mismatch_nx),
		.match_len_nx   (match_len_nx),
		.mismatch_len_nx(mismatch_len_nx),
		.edit_count_nx  (edit_count_nx),
		.word0          (word0_nx),
		.word1          (word1_nx),
		.two_words      (two_nx)
	);

	// input register: take a word whenever the slot is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1          <= s_tuser;
			ref_base_s1      <= s_tdata[BASE_BITS-1:0];
			query_base_s1    <= s_tdata[IN_BASE_W +: BASE_BITS];
			op_length_s1     <= s_tdata[2*IN_BASE_W +: LENGTH_BITS];
			query_length_s1  <= s_tdata[2*IN_BASE_W+IN_LEN_W +: LENGTH_BITS];
			query_end_pos_s1 <= s_tdata[2*IN_BASE_W+2*IN_LEN_W +: LENGTH_BITS];
		end
	end

	// commit the state update together with the results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_match_q     <= 1'b0;
			in_mismatch_q  <= 1'b0;
			match_len_q    <= '0;
			mismatch_len_q <= '0;
			edit_count_q   <= '0;
		end else if (advance) begin
			in_match_q     <= in_match_nx;
			in_mismatch_q  <= in_mismatch_nx;
			match_len_q    <= match_len_nx;
			mismatch_len_q <= mismatch_len_nx;
			edit_count_q   <= edit_count_nx;
		end
	end

	// result control: load on advance, step to the second word, drop when done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_two_q   <= 1'b0;
			res_sel_q   <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
			res_two_q   <= two_nx;
			res_sel_q   <= 1'b0;
		end else if (out_fire && m_tlast) begin
			res_valid_q <= 1'b0;
			res_sel_q   <= 1'b0;
		end else if (out_fire) begin
			res_sel_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word0_q    <= word0_nx;
			word1_q    <= word1_nx;
			res_edit_q <= edit_count_nx;
		end
	end

endmodule

FILE: hdl/cmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_checker: port-level checks for the extended CIGAR refiner
// Watches the result stream for holding, pairing and empty-result rules.
// ----------------------------------------------------------------------------
module cmr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cmr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);
	import cmr_pkg::*;

	// once reset has been seen at an edge, nothing is offered at the next one
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// an empty result carries no op and no length and closes its input
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[OP_W+CIGAR_LEN_W-1:0] == '0)
		else $error("malformed empty result");

	// the second result of a pair follows at once with the same edit total
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser
			&& m_tdata[M_TDATA_W-1:OP_W+CIGAR_LEN_W]
			== $past(m_tdata[M_TDATA_W-1:OP_W+CIGAR_LEN_W]))
		else $error("second result missing or edit total changed");

	// the first result of a pair always carries a word
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser)
		else $error("empty result leads a pair");

endmodule

bind cigar_match_mismatch_refiner cmr_checker u_cmr_checker (.*);
